### src/sqll_pkg.sv
// Shared types, constants and character helpers for the SQL query lexer.
`timescale 1ns / 1ps

package sqll_pkg;

  localparam int unsigned MAX_QUERY_LEN = 4096;
  localparam int unsigned POS_W = $clog2(MAX_QUERY_LEN + 1);
  localparam int unsigned TOK_W = 13;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned NUM_SLOTS = 3;
  localparam int unsigned NUM_KW = 5;
  localparam int unsigned KW_MAX = 8;
  localparam int unsigned KW_IDX_W = $clog2(KW_MAX);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_STAR = 8'h2a;
  localparam logic [7:0] CH_EQ = 8'h3d;
  localparam logic [7:0] CH_LT = 8'h3c;
  localparam logic [7:0] CH_GT = 8'h3e;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_DOT = 8'h2e;

  typedef enum logic [3:0] {
    TK_SELECT = 4'd0,
    TK_FROM   = 4'd1,
    TK_WHERE  = 4'd2,
    TK_AND    = 4'd3,
    TK_OR     = 4'd4,
    TK_IDENT  = 4'd5,
    TK_NUMBER = 4'd6,
    TK_STRING = 4'd7,
    TK_OPER   = 4'd8,
    TK_COMMA  = 4'd9,
    TK_STAR   = 4'd10,
    TK_END    = 4'd11,
    TK_ERROR  = 4'd12
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_UNEXPECTED   = 2'd1,
    ERR_UNTERMINATED = 2'd2,
    ERR_TOO_LONG     = 2'd3
  } err_code_e;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    tok_kind_e        kind;
    logic [TOK_W-1:0] start;
    logic [TOK_W-1:0] length;
    logic [7:0]       sym;
    err_code_e        err;
  } result_t;

  // Up to three results per input byte: a closed token, a token or error
  // begun by the byte (or the token closed by the query end), and END.
  typedef struct packed {
    logic [NUM_SLOTS-1:0] vld;
    result_t [NUM_SLOTS-1:0] slot;
  } bundle_t;

  // Keyword spellings, padded with zeros to a power-of-two row.
  localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX] = '{
    '{"S", "E", "L", "E", "C", "T", 8'h00, 8'h00},
    '{"F", "R", "O", "M", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"W", "H", "E", "R", "E", 8'h00, 8'h00, 8'h00},
    '{"A", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd6, 4'd4, 4'd5, 4'd3, 4'd2};

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  // Drops every keyword whose character at position idx is not c.
  function automatic logic [NUM_KW-1:0] kw_filter(logic [NUM_KW-1:0] mask, pos_t idx,
                                                 logic [7:0] c);
    logic [NUM_KW-1:0] m;
    m = mask;
    for (int k = 0; k < NUM_KW; k++) begin
      if (idx >= pos_t'(KW_LEN[k]) || KW_TEXT[k][idx[KW_IDX_W-1:0]] != c) begin
        m[k] = 1'b0;
      end
    end
    return m;
  endfunction

  // The lowest surviving keyword of exactly this length wins.
  function automatic tok_kind_e kw_kind(logic [NUM_KW-1:0] mask, pos_t len);
    tok_kind_e kind;
    kind = TK_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (mask[k] && len == pos_t'(KW_LEN[k])) begin
        kind = tok_kind_e'(4'(k));
      end
    end
    return kind;
  endfunction

  function automatic result_t make_result(tok_kind_e kind, pos_t start, pos_t len,
                                          logic [7:0] sym, err_code_e err);
    result_t r;
    r.kind = kind;
    r.start = TOK_W'(start);
    r.length = TOK_W'(len);
    r.sym = sym;
    r.err = err;
    return r;
  endfunction

endpackage

### src/sqll_if.sv
// Valid/ready channel interfaces for query bytes and result tokens.
`timescale 1ns / 1ps

interface sqll_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       last_char;

  modport source (output valid, char_code, has_char, last_char, input ready);
  modport sink (input valid, char_code, has_char, last_char, output ready);
endinterface

interface sqll_out_if;
  logic                       valid;
  logic                       ready;
  logic [3:0]                 token_kind;
  logic [sqll_pkg::TOK_W-1:0] token_start;
  logic [sqll_pkg::TOK_W-1:0] token_length;
  logic [7:0]                 symbol_char;
  logic [1:0]                 error_code;
  logic                       last_of_run;

  modport source (output valid, token_kind, token_start, token_length, symbol_char,
                  error_code, last_of_run, input ready);
  modport sink (input valid, token_kind, token_start, token_length, symbol_char,
                error_code, last_of_run, output ready);
endinterface

### src/sql_query_lexer.sv
// Top level of the streaming SQL query lexer.
// A byte's results enter the four-bundle queue and are offered from its head.
// Throughput: one byte per cycle; results leave one per cycle while ready is
// high; a byte with two or three results stalls the input once the queue fills.
// Reset is asynchronous: lexer state returns to idle at offset zero and the
// queue empties; there is no clearing pass.
`timescale 1ns / 1ps

module sql_query_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  sqll_in_if.sink     query_i,
  sqll_out_if.source  token_o
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  sqll_pkg::bundle_t q_in;
  sqll_pkg::bundle_t q_head;

  sqll_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (query_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .bundle_o (q_in)
  );

  sqll_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .bundle_i (q_in),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .full_o   (q_full),
    .empty_o  (q_empty)
  );

  sqll_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (q_head),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .out_o   (token_o)
  );

  // An error token carries a cause and every other token carries none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_o.valid |->
      ((token_o.token_kind == sqll_pkg::TK_ERROR) ==
       (token_o.error_code != sqll_pkg::ERR_NONE)))
    else $error("error code does not match token kind");

  // END is always the final result of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (token_o.valid && token_o.token_kind == sqll_pkg::TK_END) |->
      (token_o.last_of_run && token_o.token_length == '0))
    else $error("END token not closing its run");

  // Only operators and errors carry a symbol byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (token_o.valid && token_o.token_kind != sqll_pkg::TK_OPER &&
     token_o.token_kind != sqll_pkg::TK_ERROR) |-> token_o.symbol_char == 8'd0)
    else $error("symbol byte on a plain token");

  // The queue only drains a bundle on the transfer of its final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (!q_empty && token_o.last_of_run))
    else $error("bundle dropped before its last result");

endmodule

### src/sqll_front.sv
// Front end: accepts query bytes, runs the lexer state and builds result bundles.
`timescale 1ns / 1ps

module sqll_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  sqll_in_if.sink           in_i,
  input  logic              q_full_i,
  output logic              push_o,
  output sqll_pkg::bundle_t bundle_o
);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_ERROR  = 3'd4;

  localparam sqll_pkg::pos_t POS_MAX = sqll_pkg::pos_t'(sqll_pkg::MAX_QUERY_LEN);

  logic [2:0]                      mode_q, mode_d;
  sqll_pkg::pos_t                  pos_q, pos_d;
  sqll_pkg::pos_t                  begin_q, begin_d;
  logic [sqll_pkg::NUM_KW-1:0]     cand_q, cand_d;
  logic [7:0]                      c;
  logic                            xfer;
  logic                            run_idle;
  sqll_pkg::pos_t                  idx;
  sqll_pkg::pos_t                  end_len;
  sqll_pkg::bundle_t               bundle;

  assign c = in_i.char_code;
  assign in_i.ready = !q_full_i;
  assign xfer = in_i.valid && in_i.ready;
  assign idx = pos_q - begin_q;

  always_comb begin
    mode_d = mode_q;
    pos_d = pos_q;
    begin_d = begin_q;
    cand_d = cand_q;
    bundle = '0;
    run_idle = 1'b0;
    end_len = '0;

    if (in_i.has_char && mode_q != MODE_ERROR) begin
      if (pos_q >= POS_MAX) begin
        // Past the length limit: the pending token is dropped.
        bundle.vld[1] = 1'b1;
        bundle.slot[1] = sqll_pkg::make_result(sqll_pkg::TK_ERROR, pos_q, '0, c,
                                               sqll_pkg::ERR_TOO_LONG);
        mode_d = MODE_ERROR;
      end else begin
        unique case (mode_q)
          MODE_IDENT: begin
            if (sqll_pkg::is_alpha(c) || sqll_pkg::is_digit(c) ||
                c == sqll_pkg::CH_UNDERSCORE || c == sqll_pkg::CH_DOT) begin
              cand_d = sqll_pkg::kw_filter(cand_q, idx, c);
            end else begin
              bundle.vld[0] = 1'b1;
              bundle.slot[0] = sqll_pkg::make_result(sqll_pkg::kw_kind(cand_q, idx),
                                                     begin_q, idx, '0,
                                                     sqll_pkg::ERR_NONE);
              run_idle = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (!sqll_pkg::is_digit(c)) begin
              bundle.vld[0] = 1'b1;
              bundle.slot[0] = sqll_pkg::make_result(sqll_pkg::TK_NUMBER, begin_q, idx,
                                                     '0, sqll_pkg::ERR_NONE);
              run_idle = 1'b1;
            end
          end
          MODE_STRING: begin
            if (c == sqll_pkg::CH_QUOTE) begin
              bundle.vld[0] = 1'b1;
              bundle.slot[0] = sqll_pkg::make_result(sqll_pkg::TK_STRING, begin_q, idx,
                                                     '0, sqll_pkg::ERR_NONE);
              mode_d = MODE_IDLE;
            end
          end
          default: begin
            run_idle = 1'b1;
          end
        endcase

        if (run_idle) begin
          mode_d = MODE_IDLE;
          priority if (sqll_pkg::is_space(c)) begin
            mode_d = MODE_IDLE;
          end else if (sqll_pkg::is_alpha(c)) begin
            mode_d = MODE_IDENT;
            begin_d = pos_q;
            cand_d = sqll_pkg::kw_filter('1, '0, c);
          end else if (sqll_pkg::is_digit(c)) begin
            mode_d = MODE_NUMBER;
            begin_d = pos_q;
          end else if (c == sqll_pkg::CH_QUOTE) begin
            mode_d = MODE_STRING;
            begin_d = pos_q + 1'b1;
          end else if (c == sqll_pkg::CH_COMMA) begin
            bundle.vld[1] = 1'b1;
            bundle.slot[1] = sqll_pkg::make_result(sqll_pkg::TK_COMMA, pos_q,
                                                   sqll_pkg::pos_t'(1), '0,
                                                   sqll_pkg::ERR_NONE);
          end else if (c == sqll_pkg::CH_STAR) begin
            bundle.vld[1] = 1'b1;
            bundle.slot[1] = sqll_pkg::make_result(sqll_pkg::TK_STAR, pos_q,
                                                   sqll_pkg::pos_t'(1), '0,
                                                   sqll_pkg::ERR_NONE);
          end else if (c == sqll_pkg::CH_EQ || c == sqll_pkg::CH_LT ||
                       c == sqll_pkg::CH_GT) begin
            bundle.vld[1] = 1'b1;
            bundle.slot[1] = sqll_pkg::make_result(sqll_pkg::TK_OPER, pos_q,
                                                   sqll_pkg::pos_t'(1), c,
                                                   sqll_pkg::ERR_NONE);
          end else begin
            bundle.vld[1] = 1'b1;
            bundle.slot[1] = sqll_pkg::make_result(sqll_pkg::TK_ERROR, pos_q,
                                                   sqll_pkg::pos_t'(1), c,
                                                   sqll_pkg::ERR_UNEXPECTED);
            mode_d = MODE_ERROR;
          end
        end
        pos_d = pos_q + 1'b1;
      end
    end

    if (in_i.last_char) begin
      // A token still open at the query end closes into the middle slot,
      // which a byte that leaves a token open never uses.
      end_len = pos_d - begin_d;
      unique case (mode_d)
        MODE_IDENT: begin
          bundle.vld[1] = 1'b1;
          bundle.slot[1] = sqll_pkg::make_result(sqll_pkg::kw_kind(cand_d, end_len),
                                                 begin_d, end_len, '0,
                                                 sqll_pkg::ERR_NONE);
        end
        MODE_NUMBER: begin
          bundle.vld[1] = 1'b1;
          bundle.slot[1] = sqll_pkg::make_result(sqll_pkg::TK_NUMBER, begin_d, end_len,
                                                 '0, sqll_pkg::ERR_NONE);
        end
        MODE_STRING: begin
          bundle.vld[1] = 1'b1;
          bundle.slot[1] = sqll_pkg::make_result(sqll_pkg::TK_ERROR, begin_d - 1'b1,
                                                 end_len + 1'b1, '0,
                                                 sqll_pkg::ERR_UNTERMINATED);
        end
        default: begin
          bundle.vld[1] = bundle.vld[1];
        end
      endcase
      if (mode_d != MODE_ERROR && mode_d != MODE_STRING) begin
        bundle.vld[2] = 1'b1;
        bundle.slot[2] = sqll_pkg::make_result(sqll_pkg::TK_END, pos_d, '0, '0,
                                               sqll_pkg::ERR_NONE);
      end
      mode_d = MODE_IDLE;
      pos_d = '0;
      begin_d = '0;
      cand_d = '1;
    end
  end

  assign push_o = xfer && (|bundle.vld);
  assign bundle_o = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q <= '0;
      begin_q <= '0;
      cand_q <= '1;
    end else if (xfer) begin
      mode_q <= mode_d;
      pos_q <= pos_d;
      begin_q <= begin_d;
      cand_q <= cand_d;
    end
  end

endmodule

### src/sqll_queue.sv
// Short queue of result bundles between the lexer front end and the token emitter.
`timescale 1ns / 1ps

module sqll_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sqll_pkg::bundle_t bundle_i,
  input  logic              pop_i,
  output sqll_pkg::bundle_t head_o,
  output logic              full_o,
  output logic              empty_o
);

  sqll_pkg::bundle_t             mem_q [sqll_pkg::QUEUE_DEPTH];
  logic [sqll_pkg::QPTR_W-1:0]   wr_q, rd_q;
  logic [sqll_pkg::QCNT_W-1:0]   cnt_q;

  assign full_o = cnt_q == sqll_pkg::QCNT_W'(sqll_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### src/sqll_back.sv
// Back end: walks the head bundle and sends its results one per transfer.
`timescale 1ns / 1ps

module sqll_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sqll_pkg::bundle_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  sqll_out_if.source        out_o
);

  logic [sqll_pkg::NUM_SLOTS-1:0] done_q, done_d;
  logic [sqll_pkg::NUM_SLOTS-1:0] pending;
  logic [sqll_pkg::NUM_SLOTS-1:0] cur_oh;
  logic [1:0]                     sel;
  logic                           is_last;
  logic                           xfer;
  sqll_pkg::result_t              cur;

  assign pending = head_i.vld & ~done_q;

  always_comb begin
    priority if (pending[0]) begin
      sel = 2'd0;
    end else if (pending[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  assign cur_oh = sqll_pkg::NUM_SLOTS'(1) << sel;
  assign is_last = (pending & ~cur_oh) == '0;
  assign cur = head_i.slot[sel];

  assign out_o.valid = !empty_i;
  assign out_o.token_kind = cur.kind;
  assign out_o.token_start = cur.start;
  assign out_o.token_length = cur.length;
  assign out_o.symbol_char = cur.sym;
  assign out_o.error_code = cur.err;
  assign out_o.last_of_run = is_last;

  assign xfer = out_o.valid && out_o.ready;
  assign pop_o = xfer && is_last;

  always_comb begin
    done_d = done_q;
    if (xfer) begin
      done_d = is_last ? '0 : (done_q | cur_oh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
    end else begin
      done_q <= done_d;
    end
  end

endmodule

### verif/sqll_token_checker.sv
// Token checker: predicts the lexer's results from query transfers and compares them.
`timescale 1ns / 1ps

module sqll_token_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  sqll_in_if          query_i,
  sqll_out_if         token_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_WORD,
    SCAN_NUMBER,
    SCAN_STRING,
    SCAN_DEAD
  } scan_e;

  typedef struct {
    sqll_pkg::tok_kind_e        kind;
    logic [sqll_pkg::TOK_W-1:0] start;
    logic [sqll_pkg::TOK_W-1:0] length;
    logic [7:0]                 sym;
    sqll_pkg::err_code_e        err;
    logic                       last;
  } token_t;

  string               kw_spell [sqll_pkg::NUM_KW] = '{"SELECT", "FROM", "WHERE", "AND",
                                                       "OR"};
  sqll_pkg::tok_kind_e kw_kind [sqll_pkg::NUM_KW] = '{sqll_pkg::TK_SELECT,
                                                      sqll_pkg::TK_FROM,
                                                      sqll_pkg::TK_WHERE,
                                                      sqll_pkg::TK_AND,
                                                      sqll_pkg::TK_OR};

  scan_e                       scan;
  sqll_pkg::pos_t              pos;
  sqll_pkg::pos_t              tok_begin;
  logic [sqll_pkg::NUM_KW-1:0] kw_live;
  token_t                      batch[$];
  token_t                      token_q[$];
  int unsigned                 mismatches;

  function automatic bit blank_char(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // Clearing bit 5 folds lower case onto upper case.
  function automatic bit letter_char(logic [7:0] c);
    logic [7:0] up;
    up = c & 8'hdf;
    return up >= 8'h41 && up <= 8'h5a;
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [sqll_pkg::NUM_KW-1:0] narrow_keywords(
      logic [sqll_pkg::NUM_KW-1:0] live, int unsigned idx, logic [7:0] c);
    logic [sqll_pkg::NUM_KW-1:0] m;
    m = live;
    for (int k = 0; k < sqll_pkg::NUM_KW; k++) begin
      if (idx >= kw_spell[k].len() || kw_spell[k][idx] != c) begin
        m[k] = 1'b0;
      end
    end
    return m;
  endfunction

  task automatic push_token(sqll_pkg::tok_kind_e kind, sqll_pkg::pos_t start,
                            sqll_pkg::pos_t len, logic [7:0] sym,
                            sqll_pkg::err_code_e err);
    token_t t;
    t.kind = kind;
    t.start = sqll_pkg::TOK_W'(start);
    t.length = sqll_pkg::TOK_W'(len);
    t.sym = sym;
    t.err = err;
    t.last = 1'b0;
    batch.insert(batch.size(), t);
  endtask

  // The first keyword still alive with exactly this length names the word.
  task automatic close_word();
    sqll_pkg::tok_kind_e kind;
    sqll_pkg::pos_t      len;
    len = pos - tok_begin;
    kind = sqll_pkg::TK_IDENT;
    for (int k = sqll_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (kw_live[k] && len == kw_spell[k].len()) begin
        kind = kw_kind[k];
      end
    end
    push_token(kind, tok_begin, len, 8'h00, sqll_pkg::ERR_NONE);
  endtask

  task automatic clear_scan();
    scan = SCAN_IDLE;
    pos = '0;
    tok_begin = '0;
    kw_live = '1;
  endtask

  task automatic start_token(logic [7:0] c);
    if (!blank_char(c)) begin
      if (letter_char(c)) begin
        scan = SCAN_WORD;
        tok_begin = pos;
        kw_live = narrow_keywords('1, 0, c);
      end else if (digit_char(c)) begin
        scan = SCAN_NUMBER;
        tok_begin = pos;
      end else if (c == sqll_pkg::CH_QUOTE) begin
        scan = SCAN_STRING;
        tok_begin = pos + 1'b1;
      end else if (c == sqll_pkg::CH_COMMA) begin
        push_token(sqll_pkg::TK_COMMA, pos, sqll_pkg::pos_t'(1), 8'h00,
                   sqll_pkg::ERR_NONE);
      end else if (c == sqll_pkg::CH_STAR) begin
        push_token(sqll_pkg::TK_STAR, pos, sqll_pkg::pos_t'(1), 8'h00,
                   sqll_pkg::ERR_NONE);
      end else if (c == sqll_pkg::CH_EQ || c == sqll_pkg::CH_LT ||
                   c == sqll_pkg::CH_GT) begin
        push_token(sqll_pkg::TK_OPER, pos, sqll_pkg::pos_t'(1), c, sqll_pkg::ERR_NONE);
      end else begin
        push_token(sqll_pkg::TK_ERROR, pos, sqll_pkg::pos_t'(1), c,
                   sqll_pkg::ERR_UNEXPECTED);
        scan = SCAN_DEAD;
      end
    end
  endtask

  task automatic lex_item(logic [7:0] c, logic has, logic last);
    batch.delete();
    if (has && scan != SCAN_DEAD) begin
      if (pos >= sqll_pkg::MAX_QUERY_LEN) begin
        push_token(sqll_pkg::TK_ERROR, pos, '0, c, sqll_pkg::ERR_TOO_LONG);
        scan = SCAN_DEAD;
      end else begin
        case (scan)
          SCAN_WORD: begin
            if (letter_char(c) || digit_char(c) || c == sqll_pkg::CH_UNDERSCORE ||
                c == sqll_pkg::CH_DOT) begin
              kw_live = narrow_keywords(kw_live, pos - tok_begin, c);
            end else begin
              close_word();
              scan = SCAN_IDLE;
              start_token(c);
            end
          end
          SCAN_NUMBER: begin
            if (!digit_char(c)) begin
              push_token(sqll_pkg::TK_NUMBER, tok_begin, pos - tok_begin, 8'h00,
                         sqll_pkg::ERR_NONE);
              scan = SCAN_IDLE;
              start_token(c);
            end
          end
          SCAN_STRING: begin
            if (c == sqll_pkg::CH_QUOTE) begin
              push_token(sqll_pkg::TK_STRING, tok_begin, pos - tok_begin, 8'h00,
                         sqll_pkg::ERR_NONE);
              scan = SCAN_IDLE;
            end
          end
          default: start_token(c);
        endcase
        pos = pos + 1'b1;
      end
    end
    if (last) begin
      case (scan)
        SCAN_WORD: close_word();
        SCAN_NUMBER: push_token(sqll_pkg::TK_NUMBER, tok_begin, pos - tok_begin, 8'h00,
                                sqll_pkg::ERR_NONE);
        SCAN_STRING: begin
          // The error spans the opening quote and everything after it.
          push_token(sqll_pkg::TK_ERROR, tok_begin - 1'b1, pos - tok_begin + 1'b1, 8'h00,
                     sqll_pkg::ERR_UNTERMINATED);
          scan = SCAN_DEAD;
        end
        default: ;
      endcase
      if (scan != SCAN_DEAD) begin
        push_token(sqll_pkg::TK_END, pos, '0, 8'h00, sqll_pkg::ERR_NONE);
      end
      clear_scan();
    end
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[i]) begin
      token_q.insert(token_q.size(), batch[i]);
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic check_token();
    token_t want;
    if (token_q.size() == 0) begin
      report_mismatch($sformatf("token kind %0d start %0d length %0d with none expected",
                                token_i.token_kind, token_i.token_start,
                                token_i.token_length));
    end else begin
      want = token_q.pop_front();
      compare_field("token_kind", token_i.token_kind, want.kind);
      compare_field("token_start", token_i.token_start, want.start);
      compare_field("token_length", token_i.token_length, want.length);
      compare_field("symbol_char", token_i.symbol_char, want.sym);
      compare_field("error_code", token_i.error_code, want.err);
      compare_field("last_of_run", token_i.last_of_run, want.last);
    end
  endtask

  // Inputs are taken before outputs; a byte's results never leave in its own cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      token_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_count_o <= 0;
    end else begin
      if (query_i.valid && query_i.ready) begin
        lex_item(query_i.char_code, query_i.has_char, query_i.last_char);
      end
      if (token_i.valid && token_i.ready) begin
        check_token();
      end
      mismatch_count_o <= mismatches;
      pending_count_o <= token_q.size();
    end
  end

endmodule

### verif/testbench.sv
// Testbench top for the SQL query lexer: clock, reset, query stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned PHASE_ITEMS = 60;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned send_idle_pct = 16;
  int unsigned recv_stall_pct = 70;
  int unsigned counted_items;
  logic [7:0]  qbytes[$];
  string       kw_words [sqll_pkg::NUM_KW] = '{"SELECT", "FROM", "WHERE", "AND", "OR"};

  sqll_in_if  query_ch ();
  sqll_out_if token_ch ();

  sql_query_lexer u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .query_i (query_ch),
    .token_o (token_ch)
  );

  sqll_token_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .query_i          (query_ch),
    .token_i          (token_ch),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    token_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      token_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] random_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? 8'h61 : 8'h41;
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_word_char();
    case ($urandom_range(0, 5))
      0: return 8'h30 + 8'($urandom_range(0, 9));
      1: return sqll_pkg::CH_UNDERSCORE;
      2: return sqll_pkg::CH_DOT;
      default: return random_letter();
    endcase
  endfunction

  // Space, or one of tab, LF, VT, FF and CR.
  function automatic logic [7:0] random_blank();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 0) ? 8'h20 : 8'(8 + r);
  endfunction

  function automatic logic [7:0] random_text_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (c == sqll_pkg::CH_QUOTE);
    return c;
  endfunction

  task automatic add_byte(logic [7:0] c);
    qbytes.insert(qbytes.size(), c);
  endtask

  task automatic load_text(string s);
    qbytes.delete();
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
    end
  endtask

  task automatic send_item(logic [7:0] c, logic has, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      query_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    query_ch.valid <= 1'b1;
    query_ch.char_code <= c;
    query_ch.has_char <= has;
    query_ch.last_char <= last;
    do @(posedge clk_i); while (!query_ch.ready);
    if (has || last) begin
      counted_items++;
    end
  endtask

  task automatic wait_drained();
    query_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  // Sends qbytes as one query; the end is marked on the final byte or by an empty item.
  task automatic send_query(bit tail_empty);
    foreach (qbytes[i]) begin
      if ($urandom_range(0, 99) == 0) begin
        wait_drained();
      end
      if ($urandom_range(0, 19) == 0) begin
        send_item(8'($urandom), 1'b0, 1'b0);
      end
      send_item(qbytes[i], 1'b1, !tail_empty && i == qbytes.size() - 1);
    end
    if (tail_empty || qbytes.size() == 0) begin
      send_item(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // Noisy queries may also carry stray bytes and a string left open.
  task automatic append_tokens(int unsigned count, bit noisy);
    string       word;
    int unsigned cut;
    int unsigned flip;
    int unsigned mutate;
    repeat (count) begin
      case ($urandom_range(0, noisy ? 9 : 7))
        0, 1: begin
          // Mostly exact keywords; some are cut short, extended or have one case flipped.
          word = kw_words[$urandom_range(0, sqll_pkg::NUM_KW - 1)];
          mutate = $urandom_range(0, 7);
          cut = (mutate == 0) ? word.len() - 1 : word.len();
          flip = (mutate == 1) ? $urandom_range(0, word.len() - 1) : word.len();
          for (int i = 0; i < cut; i++) begin
            add_byte((i == flip) ? word[i] ^ 8'h20 : word[i]);
          end
          if (mutate == 2) begin
            add_byte(random_word_char());
          end
        end
        2: begin
          add_byte(random_letter());
          repeat ($urandom_range(0, 5)) add_byte(random_word_char());
        end
        3: repeat ($urandom_range(1, 4)) add_byte(8'h30 + 8'($urandom_range(0, 9)));
        4: begin
          add_byte(sqll_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 4)) add_byte(random_text_byte());
          add_byte(sqll_pkg::CH_QUOTE);
        end
        5: add_byte(sqll_pkg::CH_COMMA);
        6: add_byte(sqll_pkg::CH_STAR);
        7: begin
          case ($urandom_range(0, 2))
            0: add_byte(sqll_pkg::CH_EQ);
            1: add_byte(sqll_pkg::CH_LT);
            default: add_byte(sqll_pkg::CH_GT);
          endcase
        end
        8: add_byte(8'($urandom));
        default: begin
          add_byte(sqll_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 3)) add_byte(random_text_byte());
        end
      endcase
      repeat ($urandom_range(0, 2)) add_byte(random_blank());
    end
  endtask

  task automatic run_random(int unsigned items);
    counted_items = 0;
    while (counted_items < items) begin
      qbytes.delete();
      append_tokens($urandom_range(1, 8), $urandom_range(0, 3) == 0);
      send_query($urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    query_ch.valid = 1'b0;
    query_ch.char_code = 8'h00;
    query_ch.has_char = 1'b0;
    query_ch.last_char = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty item, then an empty query.
    send_item(8'ha5, 1'b0, 1'b0);
    qbytes.delete();
    send_query(1'b1);
    // Keyword, number closed by a comma, star, operators and a string.
    load_text("AND 7,*<=>\"s\"");
    send_query(1'b0);
    // A high byte closes a keyword and is rejected; the rest of the query is dropped.
    load_text("OR");
    add_byte(8'hff);
    add_byte(8'h78);
    send_query(1'b0);
    load_text("\"a");
    send_query(1'b0);
    load_text("9");
    send_query(1'b1);
    load_text("b,");
    send_query(1'b0);
    qbytes.delete();
    add_byte(8'h00);
    send_query(1'b0);

    run_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 70;
    recv_stall_pct = 16;
    run_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
